/* rtl/amge_pkg.sv */
// Shared types, constants and a helper function of the adjacency matrix graph engine.
package amge_pkg;

  localparam int unsigned MAX_NODES = 8;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  localparam int unsigned CNT_W     = $clog2(MAX_NODES + 1);
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 3;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(MAX_NODES);

  // Register word index of node_count on the configuration port.
  localparam logic [ADDR_W-3:0] REG_NODE_COUNT = '0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT    = 3'd0,
    FUNC_REMOVE    = 3'd1,
    FUNC_QUERY     = 3'd2,
    FUNC_DEGREE    = 3'd3,
    FUNC_POPULAR   = 3'd4,
    FUNC_RECOMMEND = 3'd5
  } func_e;

  typedef logic [MAX_NODES-1:0] row_t;

  typedef struct packed {
    logic [CNT_W-1:0]  value;
    logic [NODE_W-1:0] via_node;
    logic              found;
    logic              error;
    logic              last;
  } rsp_t;

  // Commands from the controller to the datapath; at most one is high per cycle.
  typedef struct packed {
    logic accept;
    logic pop_step;
    logic rec_step;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic start_pop;
    logic start_rec;
    logic pop_last;
    logic rec_hit;
    logic rec_end;
  } sts_t;

  // Number of set bits in one row.
  function automatic logic [CNT_W-1:0] popcount(input row_t row);
    logic [CNT_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      sum = sum + CNT_W'(row[i]);
    end
    return sum;
  endfunction

endpackage

/* rtl/amge_if.sv */
// Request and result channel interfaces of the adjacency matrix graph engine.
interface amge_req_if;
  import amge_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W-1:0] second_node;

  modport source (output valid, func, first_node, second_node, input ready);
  modport sink (input valid, func, first_node, second_node, output ready);
endinterface

interface amge_rsp_if;
  import amge_pkg::*;

  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  value;
  logic [NODE_W-1:0] via_node;
  logic              found;
  logic              error;
  logic              last;

  modport source (output valid, value, via_node, found, error, last, input ready);
  modport sink (input valid, value, via_node, found, error, last, output ready);
endinterface

/* rtl/adjacency_matrix_graph_engine.sv */
// Top level of the adjacency matrix graph engine: channels, configuration port, wiring.
//
//   Channel   Direction  Handshake         Content
//   req_i     in         valid/ready       func, first_node, second_node
//   rsp_o     out        valid/ready       value, via_node, found, error, last
//   APB       in/out     psel/penable      node_count at byte address 0
//
// Edge insert, remove, query, degree, bad indices and unused codes are decided in the
// accept cycle; their single result sits in the output register on the next cycle.
// Most popular walks the matrix one row per cycle.
// Recommend visits one (friend, candidate) pair per cycle while no hit waits on a full
// output register, and skips a non-friend row as a whole.
// Reset clears the matrix and sets node_count to 8; a new item is taken only when idle
// and the output register is empty or being emptied.
module adjacency_matrix_graph_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  amge_req_if.sink                    req_i,
  amge_rsp_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [amge_pkg::ADDR_W-1:0] paddr,
  input  logic [amge_pkg::DATA_W-1:0] pwdata,
  output logic [amge_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import amge_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rsp_t out;
  logic out_valid;

  // The controller owns the handshake on the request side and the sequencing of
  // scans; the datapath owns all data storage and produces every result.
  amge_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  amge_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_func_i   (req_i.func),
    .req_first_i  (req_i.first_node),
    .req_second_i (req_i.second_node),
    .out_o        (out),
    .out_valid_o  (out_valid),
    .out_ready_i  (rsp_o.ready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
  );

  // Every register access completes in its access cycle.
  assign pready = 1'b1;

  assign rsp_o.valid    = out_valid;
  assign rsp_o.value    = out.value;
  assign rsp_o.via_node = out.via_node;
  assign rsp_o.found    = out.found;
  assign rsp_o.error    = out.error;
  assign rsp_o.last     = out.last;

endmodule

/* rtl/amge_ctrl.sv */
// Sequencing state machine of the adjacency matrix graph engine.
module amge_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  amge_pkg::sts_t sts_i,
  output amge_pkg::cmd_t cmd_o
);
  import amge_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_REC,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o  = sts_i.out_free;
        cmd_o.accept = req_valid_i && sts_i.out_free;
        if (cmd_o.accept) begin
          if (sts_i.start_pop) begin
            state_d = S_POP;
          end else if (sts_i.start_rec) begin
            state_d = S_REC;
          end
        end
      end
      S_POP: begin
        cmd_o.pop_step = 1'b1;
        if (sts_i.pop_last) begin
          state_d = S_FIN;
        end
      end
      S_REC: begin
        // Hold the scan while a hit cannot be written to the output register.
        cmd_o.rec_step = !(sts_i.rec_hit && !sts_i.out_free);
        if (cmd_o.rec_step && sts_i.rec_end) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_pop_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP && sts_i.pop_last) |=> state_q == S_FIN)
    else $error("popular scan did not finish on its last row");

  a_rec_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rec_step && sts_i.rec_hit) |-> sts_i.out_free)
    else $error("recommendation written while the output register is full");

endmodule

/* rtl/amge_dp.sv */
// Datapath of the adjacency matrix graph engine: matrix, counters, output register.
module amge_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  amge_pkg::cmd_t                cmd_i,
  output amge_pkg::sts_t                sts_o,
  input  logic [amge_pkg::FUNC_W-1:0]   req_func_i,
  input  logic [amge_pkg::NODE_W-1:0]   req_first_i,
  input  logic [amge_pkg::NODE_W-1:0]   req_second_i,
  output amge_pkg::rsp_t                out_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [amge_pkg::ADDR_W-1:0]   paddr,
  input  logic [amge_pkg::DATA_W-1:0]   pwdata,
  output logic [amge_pkg::DATA_W-1:0]   prdata
);
  import amge_pkg::*;

  row_t              adj_q [MAX_NODES];
  row_t              adj_d [MAX_NODES];
  logic [CNT_W-1:0]  node_count_q;
  logic [NODE_W-1:0] u_q, u_d;
  row_t              row_u_q, row_u_d;
  logic              is_pop_q, is_pop_d;
  logic [NODE_W-1:0] ia_q, ia_d;
  logic [NODE_W-1:0] ib_q, ib_d;
  logic [NODE_W-1:0] best_q, best_d;
  logic [CNT_W-1:0]  bdeg_q, bdeg_d;
  rsp_t              out_q, out_d;
  logic              out_valid_q;
  logic              out_wr;

  logic [CNT_W-1:0]  n_eff;
  logic [NODE_W-1:0] last_idx;
  row_t              col_mask;
  row_t              req_row;
  row_t              scan_row;
  logic              bad_u, bad_v;
  logic [CNT_W-1:0]  row_deg;
  logic              friend;
  logic              hit;
  logic              reg_sel;

  // Effective node count limited to 1..MAX_NODES.
  always_comb begin
    if (node_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count_q > CNT_W'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count_q;
    end
  end

  assign last_idx = NODE_W'(n_eff - CNT_W'(1));

  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      col_mask[j] = CNT_W'(j) < n_eff;
    end
  end

  // The request row is read on accept; the scan row follows the friend counter.
  assign req_row  = adj_q[req_first_i];
  assign scan_row = adj_q[ia_q];
  assign row_deg  = popcount((cmd_i.accept ? req_row : scan_row) & col_mask);

  assign bad_u = {1'b0, req_first_i} >= n_eff;
  assign bad_v = {1'b0, req_second_i} >= n_eff;

  assign friend = row_u_q[ia_q];
  assign hit    = friend && scan_row[ib_q] && !row_u_q[ib_q] && (ib_q != u_q);

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.start_pop = func_e'(req_func_i) == FUNC_POPULAR;
  assign sts_o.start_rec = (func_e'(req_func_i) == FUNC_RECOMMEND) && !bad_u;
  assign sts_o.pop_last  = ia_q == last_idx;
  assign sts_o.rec_hit   = hit;
  assign sts_o.rec_end   = (ia_q == last_idx) && (!friend || ib_q == last_idx);

  always_comb begin
    adj_d    = adj_q;
    u_d      = u_q;
    row_u_d  = row_u_q;
    is_pop_d = is_pop_q;
    ia_d     = ia_q;
    ib_d     = ib_q;
    best_d   = best_q;
    bdeg_d   = bdeg_q;
    out_wr   = 1'b0;
    out_d    = '0;

    if (cmd_i.accept) begin
      u_d      = req_first_i;
      row_u_d  = req_row;
      is_pop_d = sts_o.start_pop;
      ia_d     = '0;
      ib_d     = '0;
      best_d   = '0;
      bdeg_d   = '0;
      out_d.last = 1'b1;
      case (func_e'(req_func_i))
        FUNC_INSERT, FUNC_REMOVE: begin
          out_wr = 1'b1;
          if (bad_u || bad_v) begin
            out_d.error = 1'b1;
          end else begin
            adj_d[req_first_i][req_second_i] = func_e'(req_func_i) == FUNC_INSERT;
          end
        end
        FUNC_QUERY: begin
          out_wr = 1'b1;
          if (bad_u || bad_v) begin
            out_d.error = 1'b1;
          end else begin
            out_d.value = CNT_W'(req_row[req_second_i]);
          end
        end
        FUNC_DEGREE: begin
          out_wr = 1'b1;
          if (bad_u) begin
            out_d.error = 1'b1;
          end else begin
            out_d.value = row_deg;
          end
        end
        FUNC_POPULAR: begin
          out_wr = 1'b0;
        end
        FUNC_RECOMMEND: begin
          out_wr      = bad_u;
          out_d.error = 1'b1;
        end
        default: begin
          out_wr = 1'b1;
        end
      endcase
    end

    if (cmd_i.pop_step) begin
      if (ia_q == '0 || row_deg > bdeg_q) begin
        best_d = ia_q;
        bdeg_d = row_deg;
      end
      ia_d = ia_q + NODE_W'(1);
    end

    if (cmd_i.rec_step) begin
      if (!friend) begin
        ia_d = ia_q + NODE_W'(1);
        ib_d = '0;
      end else begin
        if (hit) begin
          out_wr         = 1'b1;
          out_d.value    = CNT_W'(ib_q);
          out_d.via_node = ia_q;
          out_d.found    = 1'b1;
        end
        if (ib_q == last_idx) begin
          ia_d = ia_q + NODE_W'(1);
          ib_d = '0;
        end else begin
          ib_d = ib_q + NODE_W'(1);
        end
      end
    end

    if (cmd_i.fin) begin
      out_wr      = 1'b1;
      out_d.value = is_pop_q ? CNT_W'(best_q) : '0;
      out_d.last  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_NODES; r++) begin
        adj_q[r] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      adj_q <= adj_d;
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    u_q      <= u_d;
    row_u_q  <= row_u_d;
    is_pop_q <= is_pop_d;
    ia_q     <= ia_d;
    ib_q     <= ib_d;
    best_q   <= best_d;
    bdeg_q   <= bdeg_d;
    if (out_wr) begin
      out_q <= out_d;
    end
  end

  // Configuration register; pready is tied high at the top level.
  assign reg_sel = paddr[ADDR_W-1:2] == REG_NODE_COUNT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      node_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? DATA_W'(node_count_q) : '0;

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  a_out_free_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_wr |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before it was taken");

  a_fin_sets_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |=> (out_valid_q && out_q.last && !out_q.found))
    else $error("final result not marked as last");

endmodule
